>>> hdl/pisr_pkg.sv
// pisr_pkg: shared types, constants and the microcode program of the
// pi speed regulator. Used by every hdl module but pisr_checker; depends on nothing.
package pisr_pkg;

   localparam int unsigned PC_W     = 4;   // step counter width
   localparam int unsigned GAIN_W   = 10;
   localparam int unsigned DIVR_W   = 10;  // divisor width
   localparam int unsigned UPPER_W  = 15;
   localparam int unsigned SPEED_W  = 16;
   localparam int unsigned DRIVE_W  = 16;
   localparam int unsigned CSR_W    = 16;  // widest register
   localparam int unsigned IDX_W    = 3;
   localparam int unsigned ERR_W    = SPEED_W + 1;
   localparam int unsigned PROD_W   = 33;
   localparam int unsigned PROP_W   = 27;  // |prop| < 2**26
   localparam int unsigned ACC_W    = 28;  // sum before clamp
   localparam int unsigned BOUND_W  = 25;  // 1023 * 32767 < 2**25
   localparam int unsigned ISUM_W   = 26;  // clamped integral sum
   localparam int unsigned DIV_W    = 26;  // dividend magnitude width
   localparam int unsigned QUO_W    = DIV_W + 1;
   localparam int unsigned RES_W    = 28;
   localparam int unsigned DIV_ITER = DIV_W / 2;  // two quotient bits per cycle
   localparam int unsigned CNT_W    = 4;

   typedef enum logic [IDX_W-1:0] {
      REG_PROP_GAIN  = 3'd0,
      REG_INTEG_GAIN = 3'd1,
      REG_PROP_DIV   = 3'd2,
      REG_INTEG_DIV  = 3'd3,
      REG_OUT_UPPER  = 3'd4,
      REG_OUT_LOWER  = 3'd5
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_ACCEPT,
      OP_MUL_PROP,
      OP_MUL_INTEG,
      OP_MUL_BOUND,
      OP_ADD_SUM,
      OP_CLAMP_SUM,
      OP_LOAD_PROP,
      OP_DIV_STEP,
      OP_SAVE_PROP,
      OP_LOAD_INTEG,
      OP_ADD_RES,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      JC_NEVER,
      JC_ALWAYS,
      JC_NO_REQ,
      JC_DIV_BUSY,
      JC_RSP_FULL
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucw_type;

   typedef struct packed {
      logic req_valid;
      logic div_busy;
      logic rsp_full;
   } stat_type;

   typedef struct packed {
      logic [GAIN_W-1:0]         prop_gain;
      logic [GAIN_W-1:0]         integ_gain;
      logic [DIVR_W-1:0]         prop_div;
      logic [DIVR_W-1:0]         integ_div;
      logic [UPPER_W-1:0]        out_upper;
      logic signed [DRIVE_W-1:0] out_lower;
   } cfg_type;

   // jump targets
   localparam logic [PC_W-1:0] PC_FETCH     = 4'd0;
   localparam logic [PC_W-1:0] PC_PROP_DIV  = 4'd7;
   localparam logic [PC_W-1:0] PC_INTEG_DIV = 4'd10;
   localparam logic [PC_W-1:0] PC_WAIT_OUT  = 4'd12;

   function automatic ucw_type ucode(input logic [PC_W-1:0] pc);
      ucw_type w;
      w = '{op: OP_IDLE, cond: JC_ALWAYS, target: PC_FETCH};
      unique case (pc)
         4'd0:  w = '{op: OP_ACCEPT,     cond: JC_NO_REQ,   target: PC_FETCH};
         4'd1:  w = '{op: OP_MUL_PROP,   cond: JC_NEVER,    target: PC_FETCH};
         4'd2:  w = '{op: OP_MUL_INTEG,  cond: JC_NEVER,    target: PC_FETCH};
         4'd3:  w = '{op: OP_MUL_BOUND,  cond: JC_NEVER,    target: PC_FETCH};
         4'd4:  w = '{op: OP_ADD_SUM,    cond: JC_NEVER,    target: PC_FETCH};
         4'd5:  w = '{op: OP_CLAMP_SUM,  cond: JC_NEVER,    target: PC_FETCH};
         4'd6:  w = '{op: OP_LOAD_PROP,  cond: JC_NEVER,    target: PC_FETCH};
         4'd7:  w = '{op: OP_DIV_STEP,   cond: JC_DIV_BUSY, target: PC_PROP_DIV};
         4'd8:  w = '{op: OP_SAVE_PROP,  cond: JC_NEVER,    target: PC_FETCH};
         4'd9:  w = '{op: OP_LOAD_INTEG, cond: JC_NEVER,    target: PC_FETCH};
         4'd10: w = '{op: OP_DIV_STEP,   cond: JC_DIV_BUSY, target: PC_INTEG_DIV};
         4'd11: w = '{op: OP_ADD_RES,    cond: JC_NEVER,    target: PC_FETCH};
         4'd12: w = '{op: OP_IDLE,       cond: JC_RSP_FULL, target: PC_WAIT_OUT};
         4'd13: w = '{op: OP_EMIT,       cond: JC_ALWAYS,   target: PC_FETCH};
         default: w = '{op: OP_IDLE,     cond: JC_ALWAYS,   target: PC_FETCH};
      endcase
      return w;
   endfunction

endpackage

>>> hdl/pisr_req_if.sv
// pisr_req_if: request channel carrying measured and requested speed.
// Depends on pisr_pkg for field widths.
interface pisr_req_if;
   logic                              valid;
   logic                              ready;
   logic [pisr_pkg::SPEED_W-1:0]      speed_measured;
   logic [pisr_pkg::SPEED_W-1:0]      speed_target;

   modport source (output valid, output speed_measured, output speed_target, input ready);
   modport sink   (input valid, input speed_measured, input speed_target, output ready);
endinterface

>>> hdl/pisr_rsp_if.sv
// pisr_rsp_if: response channel carrying the clamped drive value.
// Depends on pisr_pkg for field widths.
interface pisr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pisr_pkg::DRIVE_W-1:0]  drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

>>> hdl/pisr_sequencer.sv
// pisr_sequencer: step counter, microcode lookup and conditional jumps.
// Depends on pisr_pkg (control word, status and program).
module pisr_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  pisr_pkg::stat_type  stat,
   output pisr_pkg::ucw_type   ucw
);

   logic [pisr_pkg::PC_W-1:0] pc_ff;
   logic [pisr_pkg::PC_W-1:0] pc_in;
   logic                      take;

   always_comb begin
      ucw = pisr_pkg::ucode(pc_ff);
   end

   always_comb begin
      take = 1'b0;
      unique case (ucw.cond)
         pisr_pkg::JC_NEVER:    take = 1'b0;
         pisr_pkg::JC_ALWAYS:   take = 1'b1;
         pisr_pkg::JC_NO_REQ:   take = !stat.req_valid;
         pisr_pkg::JC_DIV_BUSY: take = stat.div_busy;
         pisr_pkg::JC_RSP_FULL: take = stat.rsp_full;
         default:               take = 1'b0;
      endcase
      pc_in = take ? ucw.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= pisr_pkg::PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> hdl/pisr_divider.sv
// pisr_divider: restoring divider, two quotient bits per cycle, sign applied
// to the quotient so it truncates toward zero. Depends on pisr_pkg.
module pisr_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic                               step,
   input  logic [pisr_pkg::DIV_W-1:0]         dividend,
   input  logic                               neg,
   input  logic [pisr_pkg::DIVR_W-1:0]        divisor,
   output logic                               busy,
   output logic signed [pisr_pkg::QUO_W-1:0]  quotient
);

   localparam int unsigned DW = pisr_pkg::DIVR_W;

   logic [DW-1:0]                  rem_ff;
   logic [pisr_pkg::DIV_W-1:0]     quo_ff;
   logic [DW-1:0]                  dsor_ff;
   logic                           neg_ff;
   logic [pisr_pkg::CNT_W-1:0]     cnt_ff;

   logic [DW:0]                    trial0;
   logic [DW:0]                    trial1;
   logic [DW:0]                    rem0;
   logic [DW:0]                    rem1;
   logic                           ge0;
   logic                           ge1;

   // remainder stays below the divisor, so each trial is one bit wider
   always_comb begin
      trial0 = {rem_ff, quo_ff[pisr_pkg::DIV_W-1]};
      ge0    = trial0 >= {1'b0, dsor_ff};
      rem0   = ge0 ? trial0 - {1'b0, dsor_ff} : trial0;
      trial1 = {rem0[DW-1:0], quo_ff[pisr_pkg::DIV_W-2]};
      ge1    = trial1 >= {1'b0, dsor_ff};
      rem1   = ge1 ? trial1 - {1'b0, dsor_ff} : trial1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= pisr_pkg::CNT_W'(pisr_pkg::DIV_ITER - 1);
      end else if (step && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= '0;
         quo_ff  <= dividend;
         dsor_ff <= divisor;
         neg_ff  <= neg;
      end else if (step) begin
         rem_ff <= rem1[DW-1:0];
         quo_ff <= {quo_ff[pisr_pkg::DIV_W-3:0], ge0, ge1};
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

>>> hdl/pisr_datapath.sv
// pisr_datapath: error, shared multiplier, integral clamp, quotient sum and
// output register, all steered by the microcode op. Uses pisr_divider, pisr_pkg.
module pisr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pisr_pkg::op_type                     op,
   input  pisr_pkg::cfg_type                    cfg,
   input  logic                                 req_valid,
   input  logic [pisr_pkg::SPEED_W-1:0]         speed_measured,
   input  logic [pisr_pkg::SPEED_W-1:0]         speed_target,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [pisr_pkg::DRIVE_W-1:0]  drive,
   output logic                                 div_busy,
   output logic                                 rsp_full
);

   logic signed [pisr_pkg::ERR_W-1:0]    err_ff;
   logic signed [pisr_pkg::PROP_W-1:0]   prop_ff;
   logic signed [pisr_pkg::ACC_W-1:0]    acc_ff;
   logic [pisr_pkg::BOUND_W-1:0]         bound_ff;
   logic signed [pisr_pkg::ISUM_W-1:0]   integ_sum_ff;
   logic signed [pisr_pkg::QUO_W-1:0]    q_ff;
   logic signed [pisr_pkg::RES_W-1:0]    res_ff;
   logic signed [pisr_pkg::DRIVE_W-1:0]  drive_ff;
   logic                                 rsp_valid_ff;

   logic [pisr_pkg::DIVR_W-1:0]          pdiv;
   logic [pisr_pkg::DIVR_W-1:0]          idiv;
   logic signed [pisr_pkg::ERR_W-1:0]    mul_a;
   logic signed [pisr_pkg::DRIVE_W-1:0]  mul_b;
   logic signed [pisr_pkg::PROD_W-1:0]   product;
   logic signed [pisr_pkg::ACC_W-1:0]    bound_pos;
   logic signed [pisr_pkg::ACC_W-1:0]    acc_clamped;
   logic signed [pisr_pkg::PROP_W-1:0]   prop_mag;
   logic signed [pisr_pkg::ISUM_W-1:0]   isum_mag;
   logic                                 div_load;
   logic [pisr_pkg::DIV_W-1:0]           div_dividend;
   logic                                 div_neg;
   logic [pisr_pkg::DIVR_W-1:0]          div_divisor;
   logic signed [pisr_pkg::QUO_W-1:0]    div_quo;
   logic signed [pisr_pkg::RES_W-1:0]    upper_ext;
   logic signed [pisr_pkg::RES_W-1:0]    lower_ext;
   logic signed [pisr_pkg::DRIVE_W-1:0]  drive_sat;

   // a zero divisor acts as one
   assign pdiv = (cfg.prop_div == '0) ? pisr_pkg::DIVR_W'(1) : cfg.prop_div;
   assign idiv = (cfg.integ_div == '0) ? pisr_pkg::DIVR_W'(1) : cfg.integ_div;

   always_comb begin
      unique case (op)
         pisr_pkg::OP_MUL_INTEG: begin
            mul_a = err_ff;
            mul_b = $signed({6'b0, cfg.integ_gain});
         end
         pisr_pkg::OP_MUL_BOUND: begin
            mul_a = $signed({7'b0, idiv});
            mul_b = $signed({1'b0, cfg.out_upper});
         end
         default: begin
            mul_a = err_ff;
            mul_b = $signed({6'b0, cfg.prop_gain});
         end
      endcase
   end

   assign product = mul_a * mul_b;

   always_comb begin
      bound_pos = $signed({3'b0, bound_ff});
      if (acc_ff > bound_pos) begin
         acc_clamped = bound_pos;
      end else if (acc_ff < -bound_pos) begin
         acc_clamped = -bound_pos;
      end else begin
         acc_clamped = acc_ff;
      end
   end

   // divider operand select, magnitude and sign
   always_comb begin
      prop_mag    = prop_ff[pisr_pkg::PROP_W-1] ? -prop_ff : prop_ff;
      isum_mag    = integ_sum_ff[pisr_pkg::ISUM_W-1] ? -integ_sum_ff : integ_sum_ff;
      div_load    = (op == pisr_pkg::OP_LOAD_PROP) || (op == pisr_pkg::OP_LOAD_INTEG);
      if (op == pisr_pkg::OP_LOAD_INTEG) begin
         div_dividend = isum_mag;
         div_neg      = integ_sum_ff[pisr_pkg::ISUM_W-1];
         div_divisor  = idiv;
      end else begin
         div_dividend = prop_mag[pisr_pkg::DIV_W-1:0];
         div_neg      = prop_ff[pisr_pkg::PROP_W-1];
         div_divisor  = pdiv;
      end
   end

   pisr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .step     (op == pisr_pkg::OP_DIV_STEP),
      .dividend (div_dividend),
      .neg      (div_neg),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // upper limit is checked first, so with crossed limits a result above it takes it
   always_comb begin
      upper_ext = $signed({13'b0, cfg.out_upper});
      lower_ext = pisr_pkg::RES_W'(cfg.out_lower);
      if (res_ff > upper_ext) begin
         drive_sat = $signed({1'b0, cfg.out_upper});
      end else if (res_ff < lower_ext) begin
         drive_sat = cfg.out_lower;
      end else begin
         drive_sat = res_ff[pisr_pkg::DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      unique case (op)
         pisr_pkg::OP_ACCEPT: begin
            if (req_valid) begin
               err_ff <= $signed({1'b0, speed_target}) - $signed({1'b0, speed_measured});
            end
         end
         pisr_pkg::OP_MUL_PROP:  prop_ff  <= product[pisr_pkg::PROP_W-1:0];
         pisr_pkg::OP_MUL_INTEG: acc_ff   <= product[pisr_pkg::ACC_W-1:0];
         pisr_pkg::OP_MUL_BOUND: bound_ff <= product[pisr_pkg::BOUND_W-1:0];
         pisr_pkg::OP_ADD_SUM:   acc_ff   <= acc_ff + pisr_pkg::ACC_W'(integ_sum_ff);
         pisr_pkg::OP_SAVE_PROP: q_ff     <= div_quo;
         pisr_pkg::OP_ADD_RES:
            res_ff <= pisr_pkg::RES_W'(q_ff) + pisr_pkg::RES_W'(div_quo);
         pisr_pkg::OP_EMIT:      drive_ff <= drive_sat;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_sum_ff <= '0;
      end else if (op == pisr_pkg::OP_CLAMP_SUM) begin
         integ_sum_ff <= acc_clamped[pisr_pkg::ISUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (op == pisr_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign drive     = drive_ff;
   assign rsp_full  = rsp_valid_ff && !rsp_ready;

endmodule

>>> hdl/pi_speed_regulator.sv
// pi_speed_regulator: top level with the register file, microcode sequencer
// and datapath. Depends on pisr_pkg, pisr_req_if, pisr_rsp_if and submodules.

// PI speed regulator. Each request word carries measured and requested speed;
// one response word with the clamped drive value follows. The integral sum is
// clamped to +/- integ_divisor * out_upper, and both quotients truncate toward
// zero. After a request is accepted, the word passes twice through the shared
// two-bit-per-cycle divider, once per quotient, before its response is valid.
// A new request is taken while the last response still waits. Registers are
// written through csr_* only while no word is in flight: the user must keep to
// this, as the block itself does not enforce it; a zero divisor acts as one.
module pi_speed_regulator (
   input  logic                            clock,
   input  logic                            reset,
   pisr_req_if.sink                        req_chan,
   pisr_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [pisr_pkg::IDX_W-1:0]      csr_index,
   input  logic [pisr_pkg::CSR_W-1:0]      csr_wdata
);

   pisr_pkg::cfg_type   cfg_ff;
   pisr_pkg::ucw_type   ucw;
   pisr_pkg::stat_type  stat;
   logic                div_busy;
   logic                rsp_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= pisr_pkg::GAIN_W'(1);
         cfg_ff.integ_gain <= pisr_pkg::GAIN_W'(1);
         cfg_ff.prop_div   <= pisr_pkg::DIVR_W'(1);
         cfg_ff.integ_div  <= pisr_pkg::DIVR_W'(1);
         cfg_ff.out_upper  <= '1;
         cfg_ff.out_lower  <= {1'b1, {(pisr_pkg::DRIVE_W-1){1'b0}}};
      end else if (csr_we) begin
         unique case (csr_index)
            pisr_pkg::REG_PROP_GAIN:  cfg_ff.prop_gain  <= csr_wdata[pisr_pkg::GAIN_W-1:0];
            pisr_pkg::REG_INTEG_GAIN: cfg_ff.integ_gain <= csr_wdata[pisr_pkg::GAIN_W-1:0];
            pisr_pkg::REG_PROP_DIV:   cfg_ff.prop_div   <= csr_wdata[pisr_pkg::DIVR_W-1:0];
            pisr_pkg::REG_INTEG_DIV:  cfg_ff.integ_div  <= csr_wdata[pisr_pkg::DIVR_W-1:0];
            pisr_pkg::REG_OUT_UPPER:  cfg_ff.out_upper  <= csr_wdata[pisr_pkg::UPPER_W-1:0];
            pisr_pkg::REG_OUT_LOWER:  cfg_ff.out_lower  <= $signed(csr_wdata[pisr_pkg::DRIVE_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   assign stat = '{req_valid: req_chan.valid, div_busy: div_busy, rsp_full: rsp_full};

   pisr_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ucw   (ucw)
   );

   assign req_chan.ready = (ucw.op == pisr_pkg::OP_ACCEPT) && !reset;

   pisr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (ucw.op),
      .cfg            (cfg_ff),
      .req_valid      (req_chan.valid),
      .speed_measured (req_chan.speed_measured),
      .speed_target   (req_chan.speed_target),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .drive          (rsp_chan.drive),
      .div_busy       (div_busy),
      .rsp_full       (rsp_full)
   );

endmodule

>>> hdl/pisr_checker.sv
// pisr_checker: port-level checks of the regulator and the bind that attaches
// them to pi_speed_regulator. Depends on the top level's channel ports.
module pisr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_drive
);

   logic [2:0] pend_ff;
   logic [2:0] pend_in;

   // words accepted and not yet delivered
   always_comb begin
      pend_in = pend_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled response changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("response without a request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd2)
      else $error("too many words in flight");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind pi_speed_regulator pisr_checker u_pisr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_drive (rsp_chan.drive)
);

>>> verif/pi_speed_regulator_test.sv
// pi_speed_regulator_test: self-checking bench for the pi speed regulator, with a scripted
// opening, random phases, stalls on both channels and an internal drive predictor.
// Depends on pisr_pkg, pisr_req_if, pisr_rsp_if and pi_speed_regulator from hdl.
module pi_speed_regulator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pisr_pkg::IDX_W-1:0] IDX_SPARE_A = 3'd6;
   localparam logic [pisr_pkg::IDX_W-1:0] IDX_SPARE_B = 3'd7;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 131;
   localparam int SETTLE       = 4;
   localparam int TAIL         = 60;
   localparam int LIMIT        = 500000;

   typedef enum logic [1:0] {ROW_WRITE, ROW_WORD, ROW_WORD_KNOWN} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [pisr_pkg::IDX_W-1:0]          idx;
      logic [pisr_pkg::CSR_W-1:0]          data;
      logic [pisr_pkg::SPEED_W-1:0]        meas;
      logic [pisr_pkg::SPEED_W-1:0]        targ;
      logic signed [pisr_pkg::DRIVE_W-1:0] known;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                          csr_we    = 1'b0;
   logic [pisr_pkg::IDX_W-1:0]    csr_index = '0;
   logic [pisr_pkg::CSR_W-1:0]    csr_wdata = '0;

   pisr_req_if req_chan();
   pisr_rsp_if rsp_chan();

   pi_speed_regulator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers and the integral sum
   logic [pisr_pkg::GAIN_W-1:0]          gain_p, gain_i;
   logic [pisr_pkg::DIVR_W-1:0]          div_p, div_i;
   logic [pisr_pkg::UPPER_W-1:0]         lim_hi;
   logic signed [pisr_pkg::DRIVE_W-1:0]  lim_lo;
   longint                               integ_acc;

   logic signed [pisr_pkg::DRIVE_W-1:0]  drive_due [$];
   logic signed [pisr_pkg::DRIVE_W-1:0]  want;
   int  fail_count = 0;
   int  cycles     = 0;
   bit  gaps_on    = 1'b1;
   int  hold_len   = 0;

   step_row_type script [$];
   int  r, ph, n, mode, tgt, off, lo_mag;
   logic [pisr_pkg::CSR_W-1:0]   v_pg, v_ig, v_pd, v_id, v_hi, v_lo;
   logic [pisr_pkg::SPEED_W-1:0] w_meas, w_targ;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic signed [pisr_pkg::DRIVE_W-1:0] regulate_speed(
      input logic [pisr_pkg::SPEED_W-1:0] meas, input logic [pisr_pkg::SPEED_W-1:0] targ);
      longint err, pd, id, hi, lo, bound, prop, sum, res;
      err   = longint'(targ) - longint'(meas);
      pd    = (div_p == 0) ? 1 : longint'(div_p);
      id    = (div_i == 0) ? 1 : longint'(div_i);
      hi    = longint'(lim_hi);
      lo    = longint'(lim_lo);
      bound = id * hi;
      prop  = longint'(gain_p) * err;
      sum   = integ_acc + longint'(gain_i) * err;
      if (sum > bound) begin
         sum = bound;
      end else if (sum < -bound) begin
         sum = -bound;
      end
      integ_acc = sum;
      res = prop / pd + sum / id;
      if (res > hi) begin
         res = hi;
      end else if (res < lo) begin
         res = lo;
      end
      return res[pisr_pkg::DRIVE_W-1:0];
   endfunction

   // drop valid and wait until every drive word is back; never returns without waiting for a falling edge
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (drive_due.size() != 0);
   endtask

   task automatic write_reg(input logic [pisr_pkg::IDX_W-1:0] idx,
                            input logic [pisr_pkg::CSR_W-1:0] data);
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         pisr_pkg::REG_PROP_GAIN:  gain_p = data[pisr_pkg::GAIN_W-1:0];
         pisr_pkg::REG_INTEG_GAIN: gain_i = data[pisr_pkg::GAIN_W-1:0];
         pisr_pkg::REG_PROP_DIV:   div_p  = data[pisr_pkg::DIVR_W-1:0];
         pisr_pkg::REG_INTEG_DIV:  div_i  = data[pisr_pkg::DIVR_W-1:0];
         pisr_pkg::REG_OUT_UPPER:  lim_hi = data[pisr_pkg::UPPER_W-1:0];
         pisr_pkg::REG_OUT_LOWER:  lim_lo = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // called at a falling edge; returns at the falling edge after acceptance with valid high
   task automatic push_word(input logic [pisr_pkg::SPEED_W-1:0] meas,
                            input logic [pisr_pkg::SPEED_W-1:0] targ,
                            input bit fixed,
                            input logic signed [pisr_pkg::DRIVE_W-1:0] known);
      logic signed [pisr_pkg::DRIVE_W-1:0] pred;
      while (gaps_on && $urandom_range(99) < 34) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.speed_measured <= meas;
      req_chan.speed_target   <= targ;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pred = regulate_speed(meas, targ);
      drive_due.push_back(fixed ? known : pred);
      @(negedge clock);
   endtask

   // receiver: random back-pressure plus a long hold-off on request
   initial begin
      int hold_cnt;
      hold_cnt = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len != 0) begin
            hold_cnt = hold_len;
            hold_len = 0;
         end
         if (hold_cnt > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_cnt--;
         end else begin
            rsp_chan.ready <= !(gaps_on && $urandom_range(99) < 34);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (drive_due.size() == 0) begin
            $error("drive: no word expected, got %0d", rsp_chan.drive);
            fail_count++;
         end else begin
            want = drive_due.pop_front();
            if (rsp_chan.drive !== want) begin
               $error("drive: expected %0d, got %0d", want, rsp_chan.drive);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAIL pi_speed_regulator");
         $finish;
      end
   end

   initial begin
      req_chan.valid          = 1'b0;
      req_chan.speed_measured = '0;
      req_chan.speed_target   = '0;
      gain_p    = 10'd1;
      gain_i    = 10'd1;
      div_p     = 10'd1;
      div_i     = 10'd1;
      lim_hi    = 15'h7FFF;
      lim_lo    = 16'h8000;
      integ_acc = 0;

      script = '{
         '{ROW_WORD_KNOWN, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd0, 16'd0, 16'h0000},
         '{ROW_WORD_KNOWN, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd0, 16'hFFFF, 16'h7FFF},
         '{ROW_WORD_KNOWN, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'hFFFF, 16'd0, 16'h8000},
         '{ROW_WORD_KNOWN, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd100, 16'd100, 16'h8001},
         // zero gains leave the integral sum where it is
         '{ROW_WRITE, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_INTEG_GAIN, 16'd0, 16'd0, 16'd0, 16'h0000},
         '{ROW_WORD_KNOWN, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd0, 16'hFFFF, 16'h8001},
         // zero divisors act as one
         '{ROW_WRITE, pisr_pkg::REG_PROP_DIV, 16'd0, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_INTEG_DIV, 16'd0, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_PROP_GAIN, 16'd1023, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_INTEG_GAIN, 16'd1023, 16'd0, 16'd0, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd1000, 16'd1010, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd1010, 16'd1000, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_PROP_DIV, 16'd1023, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_INTEG_DIV, 16'd1023, 16'd0, 16'd0, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd0, 16'hFFFF, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'hFFFF, 16'd0, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd30000, 16'd30007, 16'h0000},
         // zero upper limit pins the integral clamp to zero
         '{ROW_WRITE, pisr_pkg::REG_OUT_UPPER, 16'd0, 16'd0, 16'd0, 16'h0000},
         '{ROW_WORD_KNOWN, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd0, 16'hFFFF, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'hFFFF, 16'd0, 16'h0000},
         // positive lower limit above the upper one
         '{ROW_WRITE, pisr_pkg::REG_OUT_UPPER, 16'd100, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_OUT_LOWER, 16'd200, 16'd0, 16'd0, 16'h0000},
         '{ROW_WORD_KNOWN, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd0, 16'hFFFF, 16'd100},
         '{ROW_WORD_KNOWN, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'hFFFF, 16'd0, 16'd200},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd50, 16'd50, 16'h0000},
         // writes to unused indexes must not land anywhere
         '{ROW_WRITE, IDX_SPARE_A, 16'h1234, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, IDX_SPARE_B, 16'hFFFF, 16'd0, 16'd0, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'd123, 16'd456, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_OUT_LOWER, 16'h8000, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_OUT_UPPER, 16'h7FFF, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_PROP_GAIN, 16'd1, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_INTEG_GAIN, 16'd1, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_PROP_DIV, 16'd1, 16'd0, 16'd0, 16'h0000},
         '{ROW_WRITE, pisr_pkg::REG_INTEG_DIV, 16'd1, 16'd0, 16'd0, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'hAAAA, 16'h5555, 16'h0000},
         '{ROW_WORD, pisr_pkg::REG_PROP_GAIN, 16'd0, 16'h5555, 16'hAAAA, 16'h0000}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (r = 0; r < script.size(); r++) begin
         if (script[r].kind == ROW_WRITE) begin
            write_reg(script[r].idx, script[r].data);
         end else begin
            push_word(script[r].meas, script[r].targ,
                      script[r].kind == ROW_WORD_KNOWN, script[r].known);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               v_pg = 16'd1; v_ig = 16'd1; v_pd = 16'd1; v_id = 16'd1;
               v_hi = 16'h7FFF; v_lo = 16'h8000;
            end
            1: begin
               v_pg = 16'd1023; v_ig = 16'd1023; v_pd = 16'd1023; v_id = 16'd1023;
               v_hi = 16'h7FFF; v_lo = 16'd0;
            end
            default: begin
               v_pg = 16'($urandom_range(0, 1023));
               v_ig = 16'($urandom_range(0, 1023));
               v_pd = 16'($urandom_range(0, 1023));
               v_id = 16'($urandom_range(0, 1023));
               v_hi = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32767))
                                                  : 16'($urandom_range(16384, 32767));
               lo_mag = int'($urandom_range(0, 32768));
               v_lo = 16'(0 - lo_mag);
               if ($urandom_range(0, 9) == 0) v_lo = 16'($urandom_range(0, 500));
            end
         endcase
         write_reg(pisr_pkg::REG_PROP_GAIN, v_pg);
         write_reg(pisr_pkg::REG_INTEG_GAIN, v_ig);
         write_reg(pisr_pkg::REG_PROP_DIV, v_pd);
         write_reg(pisr_pkg::REG_INTEG_DIV, v_id);
         write_reg(pisr_pkg::REG_OUT_UPPER, v_hi);
         write_reg(pisr_pkg::REG_OUT_LOWER, v_lo);

         gaps_on = (ph != 2);
         // long receiver hold-off so the block backs up into the request side
         if (ph == 3) hold_len = 400;

         for (n = 0; n < PHASE_WORDS; n++) begin
            if (ph == 4 && n == PHASE_WORDS / 2) drain();
            mode = int'($urandom_range(0, 9));
            if (mode < 6) begin
               tgt = int'($urandom_range(0, 65535));
               off = int'($urandom_range(0, 400)) - 200;
               off = tgt + off;
               if (off < 0) off = 0;
               if (off > 65535) off = 65535;
               w_targ = 16'(tgt);
               w_meas = 16'(off);
            end else if (mode < 9) begin
               w_meas = 16'($urandom_range(0, 65535));
               w_targ = 16'($urandom_range(0, 65535));
            end else begin
               w_meas = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               w_targ = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            push_word(w_meas, w_targ, 1'b0, '0);
         end
         gaps_on = 1'b1;
      end

      drain();
      repeat (TAIL) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS pi_speed_regulator");
      end else begin
         $display("FAIL pi_speed_regulator");
      end
      $finish;
   end

endmodule
